[rtl/icda_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icda_pkg: shared types and constants of the counter delta accumulator
// Item layouts, stored row layouts and register indexes.
// ----------------------------------------------------------------------------
package icda_pkg;

   // Default number of adaptors
   localparam int ADAPTORS_DEF = 16;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_NARROW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WIDE   = 2'd1;

   // Reset limits
   localparam logic [31:0] LIMIT_NARROW_RST = 32'hFFFF_FFFF;
   localparam logic [63:0] LIMIT_WIDE_RST   = 64'hFFFF_FFFF_FFFF_FFFF;

   // Event slots: pkts, errs, drops in, then out
   localparam int EV_PKTS_IN  = 0;
   localparam int EV_PKTS_OUT = 3;

   typedef logic [1:0][63:0] bytes_type;
   typedef logic [5:0][31:0] events_type;
   typedef logic [1:0][31:0] lows_type;

   typedef struct packed {
      logic [3:0]  adaptor;
      logic [63:0] raw_bytes_in;
      logic [31:0] raw_pkts_in;
      logic [31:0] raw_errs_in;
      logic [31:0] raw_drops_in;
      logic [63:0] raw_bytes_out;
      logic [31:0] raw_pkts_out;
      logic [31:0] raw_errs_out;
      logic [31:0] raw_drops_out;
   } req_type;

   typedef struct packed {
      logic [63:0] total_bytes_in;
      logic [31:0] total_pkts_in;
      logic [31:0] total_errs_in;
      logic [31:0] total_drops_in;
      logic [63:0] total_bytes_out;
      logic [31:0] total_pkts_out;
      logic [31:0] total_errs_out;
      logic [31:0] total_drops_out;
      logic        discontinuity;
      logic        first_sample;
      logic        wide_mode_now;
   } rsp_type;

   // Per-adaptor snapshot row
   typedef struct packed {
      bytes_type  bytes;
      events_type events;
      lows_type   lows;
   } hist_type;

   // Per-adaptor totals row
   typedef struct packed {
      logic       seen;
      bytes_type  bytes;
      events_type events;
   } totals_type;

   // Delta stage to accumulate stage
   typedef struct packed {
      logic       valid;
      logic       exceed;
      bytes_type  bytes;
      events_type events;
   } delta_type;

   function automatic bytes_type req_bytes(req_type r);
      bytes_type b;
      b[0] = r.raw_bytes_in;
      b[1] = r.raw_bytes_out;
      return b;
   endfunction

   function automatic events_type req_events(req_type r);
      events_type e;
      e[0] = r.raw_pkts_in;
      e[1] = r.raw_errs_in;
      e[2] = r.raw_drops_in;
      e[3] = r.raw_pkts_out;
      e[4] = r.raw_errs_out;
      e[5] = r.raw_drops_out;
      return e;
   endfunction

endpackage
`default_nettype wire

[rtl/interface_counter_delta_accumulator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interface_counter_delta_accumulator: per-adaptor counter delta accumulator
// Takes polls of raw adaptor counters, accumulates wrap-around deltas into
// per-adaptor totals and returns the totals.
//
//   channel  ports                               flow
//   request  start, busy, req_data               start taken when busy low
//   result   rsp_valid, rsp_data                 one-cycle strobe, no stall
//   csr      csr_valid, csr_ready, csr_index,    write taken on valid&ready
//            csr_wdata
//
// The snapshot memory read and write-back in the delta stage hold busy high
// after each in-range item is taken, so no new item is taken while one is
// in the delta stage. The result strobes once the item has passed the read,
// delta and result registers. After reset, busy stays high while the totals
// memory is cleared one row a cycle. Items naming an adaptor of ADAPTORS or
// above are taken and dropped without a result.
// ----------------------------------------------------------------------------
module interface_counter_delta_accumulator #(
   parameter int ADAPTORS = icda_pkg::ADAPTORS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  icda_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   output icda_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [icda_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [63:0]                       csr_wdata
);
   import icda_pkg::*;

   localparam int AW = (ADAPTORS > 1) ? $clog2(ADAPTORS) : 1;

   logic [31:0]   max_narrow_ff;
   logic [63:0]   max_wide_ff;
   logic [AW+3:0] adaptor_ext;
   logic          in_range;
   logic          launch;
   logic          look_valid;
   logic [AW-1:0] look_addr;
   delta_type     dlt;
   logic          wide_mode;
   logic          clear_busy;

   // Decode the adaptor index and launch in-range items
   assign adaptor_ext = {{AW{1'b0}}, req_data.adaptor};
   assign in_range = adaptor_ext < (AW+4)'(ADAPTORS);
   assign busy = clear_busy || look_valid;
   assign launch = start && !busy && in_range;
   assign csr_ready = 1'b1;

   // Hold the limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_narrow_ff <= LIMIT_NARROW_RST;
         max_wide_ff <= LIMIT_WIDE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_NARROW: max_narrow_ff <= csr_wdata[31:0];
            CSR_MAX_WIDE:   max_wide_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   icda_delta #(.ADAPTORS(ADAPTORS)) u_delta (
      .clock      (clock),
      .reset      (reset),
      .launch     (launch),
      .req        (req_data),
      .addr       (adaptor_ext[AW-1:0]),
      .max_narrow (max_narrow_ff),
      .max_wide   (max_wide_ff),
      .look_valid (look_valid),
      .look_addr  (look_addr),
      .dlt        (dlt),
      .wide_mode  (wide_mode)
   );

   icda_accum #(.ADAPTORS(ADAPTORS)) u_accum (
      .clock      (clock),
      .reset      (reset),
      .look_valid (look_valid),
      .look_addr  (look_addr),
      .dlt        (dlt),
      .wide_mode  (wide_mode),
      .clear_busy (clear_busy),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp_data)
   );

endmodule
`default_nettype wire

[rtl/icda_delta.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icda_delta: snapshot memory and delta stage
// Reads the adaptor's last raw counters, takes wrap-around deltas, checks
// them against the limits, writes the new snapshot back and tracks wide mode.
// ----------------------------------------------------------------------------
module icda_delta #(
   parameter int ADAPTORS = icda_pkg::ADAPTORS_DEF,
   localparam int AW = (ADAPTORS > 1) ? $clog2(ADAPTORS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                launch,
   input  icda_pkg::req_type   req,
   input  logic [AW-1:0]       addr,
   input  logic [31:0]         max_narrow,
   input  logic [63:0]         max_wide,
   output logic                look_valid,
   output logic [AW-1:0]       look_addr,
   output icda_pkg::delta_type dlt,
   output logic                wide_mode
);
   import icda_pkg::*;

   hist_type    hist_mem [ADAPTORS];
   hist_type    hist_rd_ff;
   hist_type    hist_wr;
   req_type     req_ff;
   logic [AW-1:0] addr_ff;
   logic        launch_ff;
   logic        wide_mode_ff;
   logic        wide_mode_in;
   delta_type   dlt_ff;
   delta_type   dlt_in;
   bytes_type   raw_b;
   events_type  raw_e;
   logic [63:0] limit;

   // Take deltas and check limits on the row just read
   always_comb begin
      raw_b = req_bytes(req_ff);
      raw_e = req_events(req_ff);
      dlt_in.valid = launch_ff;
      hist_wr.bytes = raw_b;
      hist_wr.events = raw_e;
      for (int k = 0; k < 6; k++) begin
         dlt_in.events[k] = raw_e[k] - hist_rd_ff.events[k];
      end
      for (int k = 0; k < 2; k++) begin
         if (wide_mode_ff) begin
            dlt_in.bytes[k] = raw_b[k] - hist_rd_ff.bytes[k];
            hist_wr.lows[k] = hist_rd_ff.lows[k];
         end else begin
            dlt_in.bytes[k] = {32'd0, raw_b[k][31:0] - hist_rd_ff.lows[k]};
            hist_wr.lows[k] = raw_b[k][31:0];
         end
      end
      limit = wide_mode_ff ? max_wide : {32'd0, max_narrow};
      dlt_in.exceed = (dlt_in.bytes[0] > limit) || (dlt_in.bytes[1] > limit) ||
                      (dlt_in.events[EV_PKTS_IN] > max_narrow) ||
                      (dlt_in.events[EV_PKTS_OUT] > max_narrow);
      wide_mode_in = wide_mode_ff || (raw_b[0][63:32] != 32'd0) ||
                     (raw_b[1][63:32] != 32'd0);
   end

   // Control and delta registers: launch flag, delta item, wide mode
   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff <= 1'b0;
         dlt_ff.valid <= 1'b0;
         wide_mode_ff <= 1'b0;
      end else begin
         launch_ff <= launch;
         dlt_ff.valid <= dlt_in.valid;
         if (launch_ff) begin
            wide_mode_ff <= wide_mode_in;
         end
      end
      if (launch_ff) begin
         dlt_ff.exceed <= dlt_in.exceed;
         dlt_ff.bytes <= dlt_in.bytes;
         dlt_ff.events <= dlt_in.events;
      end
   end

   // Payload registers and snapshot memory
   always_ff @(posedge clock) begin
      if (launch) begin
         req_ff <= req;
         addr_ff <= addr;
         hist_rd_ff <= hist_mem[addr];
      end
      if (launch_ff) begin
         hist_mem[addr_ff] <= hist_wr;
      end
   end

   assign look_valid = launch_ff;
   assign look_addr = addr_ff;
   assign dlt = dlt_ff;
   assign wide_mode = wide_mode_ff;

`ifndef NO_ASSERTIONS
   // No item is launched while launch_ff still holds the previous one
   a_launch_spacing: assert property (@(posedge clock) disable iff (reset)
      launch_ff |-> !launch) else $error("item launched while delta stage busy");

   // Each read row produces exactly one delta
   a_delta_follows: assert property (@(posedge clock) disable iff (reset)
      launch_ff |=> dlt_ff.valid) else $error("delta missing after read");

   // Wide mode never turns off
   a_wide_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(wide_mode_ff)) else $error("wide mode dropped");
`endif

endmodule
`default_nettype wire

[rtl/icda_accum.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icda_accum: totals memory and accumulate stage
// Clears the totals after reset, adds accepted deltas to the adaptor's
// totals, writes them back and registers the result item.
// ----------------------------------------------------------------------------
module icda_accum #(
   parameter int ADAPTORS = icda_pkg::ADAPTORS_DEF,
   localparam int AW = (ADAPTORS > 1) ? $clog2(ADAPTORS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                look_valid,
   input  logic [AW-1:0]       look_addr,
   input  icda_pkg::delta_type dlt,
   input  logic                wide_mode,
   output logic                clear_busy,
   output logic                rsp_valid,
   output icda_pkg::rsp_type   rsp
);
   import icda_pkg::*;

   totals_type    tot_mem [ADAPTORS];
   totals_type    tot_rd_ff;
   totals_type    tot_in;
   logic [AW-1:0] wr_addr_ff;
   logic          clr_active_ff;
   logic [AW-1:0] clr_addr_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          accumulate;

   // Add deltas unless this is a first sample or a limit was exceeded
   always_comb begin
      accumulate = tot_rd_ff.seen && !dlt.exceed;
      tot_in.seen = 1'b1;
      for (int k = 0; k < 2; k++) begin
         tot_in.bytes[k] = accumulate ? tot_rd_ff.bytes[k] + dlt.bytes[k]
                                      : tot_rd_ff.bytes[k];
      end
      for (int k = 0; k < 6; k++) begin
         tot_in.events[k] = accumulate ? tot_rd_ff.events[k] + dlt.events[k]
                                       : tot_rd_ff.events[k];
      end
      rsp_in.total_bytes_in  = tot_in.bytes[0];
      rsp_in.total_pkts_in   = tot_in.events[0];
      rsp_in.total_errs_in   = tot_in.events[1];
      rsp_in.total_drops_in  = tot_in.events[2];
      rsp_in.total_bytes_out = tot_in.bytes[1];
      rsp_in.total_pkts_out  = tot_in.events[3];
      rsp_in.total_errs_out  = tot_in.events[4];
      rsp_in.total_drops_out = tot_in.events[5];
      rsp_in.discontinuity   = tot_rd_ff.seen && dlt.exceed;
      rsp_in.first_sample    = !tot_rd_ff.seen;
      rsp_in.wide_mode_now   = wide_mode;
   end

   // Control: clearing pass and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dlt.valid;
         if (clr_active_ff) begin
            if (clr_addr_ff == AW'(ADAPTORS - 1)) begin
               clr_active_ff <= 1'b0;
            end else begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
            end
         end
      end
   end

   // Totals memory: clear, read ahead of the delta, write back
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         tot_mem[clr_addr_ff] <= '0;
      end else if (dlt.valid) begin
         tot_mem[wr_addr_ff] <= tot_in;
      end
      if (look_valid) begin
         tot_rd_ff <= tot_mem[look_addr];
         wr_addr_ff <= look_addr;
      end
      if (dlt.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign clear_busy = clr_active_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

`ifndef NO_ASSERTIONS
   // No item reaches the totals while they are being cleared
   a_no_item_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !look_valid && !dlt.valid) else $error("item during clear");

   // Every delta yields one result in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      dlt.valid |=> rsp_valid_ff) else $error("result missing");

   // A first sample is never flagged as a discontinuity
   a_first_not_disc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.first_sample && rsp_ff.discontinuity))
      else $error("first sample flagged as discontinuity");
`endif

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for interface_counter_delta_accumulator
// Drives adaptor counter polls through the start/busy port, predicts the
// returned totals with a local copy of the per-adaptor history, and compares
// every strobed result field by field. A directed table covers the narrow
// byte mode, limit boundaries and unused registers; random polls follow in
// several limit settings, then a second table moves the block to 64-bit byte
// counters and random polls run on in that mode.
// ----------------------------------------------------------------------------
module testbench;
   import icda_pkg::*;

   localparam int ADAPTORS = ADAPTORS_DEF;
   // Adaptor kept out of the narrow random polls so it first shows up in wide mode
   localparam logic [3:0] FRESH_ADAPTOR = 4'd14;
   // Register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_B = 2'd3;
   localparam logic [63:0] LOW_WORD = 64'h0000_0000_FFFF_FFFF;

   typedef enum logic {ROW_POLL, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      req_type               poll;
      bit                    typed;
      rsp_type               want;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [63:0]           reg_value;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [63:0]            csr_wdata;

   // Typed expectation riding along with the poll on the port
   bit                     poll_typed;
   rsp_type                poll_want;

   // Predicted block state
   logic                   poll_seen   [ADAPTORS];
   logic [63:0]            last_bytes  [ADAPTORS][2];
   logic [31:0]            last_events [ADAPTORS][6];
   logic [31:0]            last_lows   [ADAPTORS][2];
   logic [63:0]            sum_bytes   [ADAPTORS][2];
   logic [31:0]            sum_events  [ADAPTORS][6];
   logic                   wide_counters;
   logic [31:0]            narrow_limit;
   logic [63:0]            wide_limit;

   // Raw counters as the random polls advance them
   logic [63:0]            gen_bytes  [ADAPTORS][2];
   logic [31:0]            gen_events [ADAPTORS][6];

   rsp_type                expected_totals [$];
   stim_row_type           narrow_plan [$];
   stim_row_type           wide_plan [$];
   int                     error_count = 0;

   interface_counter_delta_accumulator #(.ADAPTORS(ADAPTORS)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch(name, got, want);
   endtask

   // Apply one poll to the predicted history; return 0 when no result follows
   function automatic bit accumulate_poll(input req_type poll, output rsp_type totals);
      logic [3:0]  a;
      logic [63:0] raw_b [2];
      logic [31:0] raw_e [6];
      logic [63:0] d_b [2];
      logic [31:0] d_e [6];
      logic [31:0] low_delta;
      logic [63:0] limit;
      logic        first;
      logic        disc;
      a = poll.adaptor;
      totals = '0;
      if (int'(a) >= ADAPTORS)
         return 1'b0;
      raw_b[0] = poll.raw_bytes_in;
      raw_b[1] = poll.raw_bytes_out;
      raw_e[0] = poll.raw_pkts_in;
      raw_e[1] = poll.raw_errs_in;
      raw_e[2] = poll.raw_drops_in;
      raw_e[3] = poll.raw_pkts_out;
      raw_e[4] = poll.raw_errs_out;
      raw_e[5] = poll.raw_drops_out;
      first = !poll_seen[a];
      poll_seen[a] = 1'b1;
      for (int k = 0; k < 6; k++)
         d_e[k] = raw_e[k] - last_events[a][k];
      // Byte deltas: full width once wide, else low word against its own snapshot
      if (wide_counters) begin
         for (int k = 0; k < 2; k++)
            d_b[k] = raw_b[k] - last_bytes[a][k];
         limit = wide_limit;
      end else begin
         for (int k = 0; k < 2; k++) begin
            low_delta = raw_b[k][31:0] - last_lows[a][k];
            d_b[k] = {32'd0, low_delta};
            last_lows[a][k] = raw_b[k][31:0];
         end
         limit = {32'd0, narrow_limit};
         if (raw_b[0][63:32] != 32'd0 || raw_b[1][63:32] != 32'd0)
            wide_counters = 1'b1;
      end
      disc = !first && (d_b[0] > limit || d_b[1] > limit ||
                        d_e[EV_PKTS_IN] > narrow_limit || d_e[EV_PKTS_OUT] > narrow_limit);
      if (!first && !disc) begin
         for (int k = 0; k < 2; k++)
            sum_bytes[a][k] += d_b[k];
         for (int k = 0; k < 6; k++)
            sum_events[a][k] += d_e[k];
      end
      for (int k = 0; k < 2; k++)
         last_bytes[a][k] = raw_b[k];
      for (int k = 0; k < 6; k++)
         last_events[a][k] = raw_e[k];
      totals.total_bytes_in  = sum_bytes[a][0];
      totals.total_pkts_in   = sum_events[a][0];
      totals.total_errs_in   = sum_events[a][1];
      totals.total_drops_in  = sum_events[a][2];
      totals.total_bytes_out = sum_bytes[a][1];
      totals.total_pkts_out  = sum_events[a][3];
      totals.total_errs_out  = sum_events[a][4];
      totals.total_drops_out = sum_events[a][5];
      totals.discontinuity   = disc;
      totals.first_sample    = first;
      totals.wide_mode_now   = wide_counters;
      return 1'b1;
   endfunction

   // Check strobed totals, record accepted polls and register writes
   always @(posedge clock) begin : scoreboard
      rsp_type predicted;
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < ADAPTORS; i++) begin
            poll_seen[i] = 1'b0;
            for (int k = 0; k < 2; k++) begin
               last_bytes[i][k] = '0;
               last_lows[i][k]  = '0;
               sum_bytes[i][k]  = '0;
            end
            for (int k = 0; k < 6; k++) begin
               last_events[i][k] = '0;
               sum_events[i][k]  = '0;
            end
         end
         wide_counters = 1'b0;
         narrow_limit  = LIMIT_NARROW_RST;
         wide_limit    = LIMIT_WIDE_RST;
         expected_totals.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_totals.size() == 0) begin
               report_mismatch("result with nothing pending", 64'd0, 64'd0);
            end else begin
               want = expected_totals.pop_front();
               check_field("total_bytes_in", rsp_data.total_bytes_in, want.total_bytes_in);
               check_field("total_pkts_in", rsp_data.total_pkts_in, want.total_pkts_in);
               check_field("total_errs_in", rsp_data.total_errs_in, want.total_errs_in);
               check_field("total_drops_in", rsp_data.total_drops_in, want.total_drops_in);
               check_field("total_bytes_out", rsp_data.total_bytes_out,
                           want.total_bytes_out);
               check_field("total_pkts_out", rsp_data.total_pkts_out, want.total_pkts_out);
               check_field("total_errs_out", rsp_data.total_errs_out, want.total_errs_out);
               check_field("total_drops_out", rsp_data.total_drops_out,
                           want.total_drops_out);
               check_field("discontinuity", rsp_data.discontinuity, want.discontinuity);
               check_field("first_sample", rsp_data.first_sample, want.first_sample);
               check_field("wide_mode_now", rsp_data.wide_mode_now, want.wide_mode_now);
            end
         end
         if (start && !busy && accumulate_poll(req_data, predicted))
            expected_totals.push_back(poll_typed ? poll_want : predicted);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_NARROW: narrow_limit = csr_wdata[31:0];
               CSR_MAX_WIDE:   wide_limit   = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   function automatic req_type poll_of(input logic [3:0] a, input logic [63:0] bi,
                                       input logic [31:0] pi, ei, di,
                                       input logic [63:0] bo,
                                       input logic [31:0] po, eo, dro);
      req_type p;
      p.adaptor       = a;
      p.raw_bytes_in  = bi;
      p.raw_pkts_in   = pi;
      p.raw_errs_in   = ei;
      p.raw_drops_in  = di;
      p.raw_bytes_out = bo;
      p.raw_pkts_out  = po;
      p.raw_errs_out  = eo;
      p.raw_drops_out = dro;
      return p;
   endfunction

   function automatic rsp_type totals_of(input logic [63:0] bi, input logic [31:0] pi, ei, di,
                                         input logic [63:0] bo, input logic [31:0] po, eo, dro,
                                         input logic disc, first, wide);
      rsp_type t;
      t.total_bytes_in  = bi;
      t.total_pkts_in   = pi;
      t.total_errs_in   = ei;
      t.total_drops_in  = di;
      t.total_bytes_out = bo;
      t.total_pkts_out  = po;
      t.total_errs_out  = eo;
      t.total_drops_out = dro;
      t.discontinuity   = disc;
      t.first_sample    = first;
      t.wide_mode_now   = wide;
      return t;
   endfunction

   function automatic stim_row_type poll_row(input req_type p);
      stim_row_type r;
      r.kind      = ROW_POLL;
      r.poll      = p;
      r.typed     = 1'b0;
      r.want      = '0;
      r.reg_index = CSR_MAX_NARROW;
      r.reg_value = '0;
      return r;
   endfunction

   function automatic stim_row_type checked_row(input req_type p, input rsp_type w);
      stim_row_type r;
      r = poll_row(p);
      r.typed = 1'b1;
      r.want  = w;
      return r;
   endfunction

   function automatic stim_row_type reg_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [63:0] v);
      stim_row_type r;
      r = poll_row('0);
      r.kind      = ROW_REG;
      r.reg_index = idx;
      r.reg_value = v;
      return r;
   endfunction

   // Move a raw counter: mostly small steps, sometimes stalls, wraps or jumps
   function automatic logic [63:0] bump(input logic [63:0] v, input int unsigned span,
                                        input bit wide);
      logic [63:0] top;
      logic [63:0] nv;
      int unsigned sel;
      top = wide ? '1 : LOW_WORD;
      sel = $urandom_range(0, 99);
      if (sel < 94)
         nv = v + 64'($urandom_range(0, span));
      else if (sel < 95)
         nv = v;
      else if (sel < 97)
         nv = top - 64'($urandom_range(0, span));
      else if (sel < 99)
         nv = v + (wide ? {24'd0, 8'($urandom), $urandom} : {32'd0, $urandom});
      else
         nv = {$urandom, $urandom};
      return wide ? nv : (nv & LOW_WORD);
   endfunction

   function automatic req_type next_poll(input logic [3:0] a, input bit wide);
      for (int k = 0; k < 2; k++)
         gen_bytes[a][k] = bump(gen_bytes[a][k], 6000, wide);
      for (int k = 0; k < 6; k++)
         gen_events[a][k] = 32'(bump({32'd0, gen_events[a][k]}, 150, 1'b0));
      return poll_of(a, gen_bytes[a][0], gen_events[a][0], gen_events[a][1],
                     gen_events[a][2], gen_bytes[a][1], gen_events[a][3],
                     gen_events[a][4], gen_events[a][5]);
   endfunction

   // Hold the next item until every pending result has arrived
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (expected_totals.size() != 0)
         @(posedge clock);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_poll(input req_type poll, input bit typed, input rsp_type want);
      start      <= 1'b1;
      req_data   <= poll;
      poll_typed <= typed;
      poll_want  <= want;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // Write a register once the block has gone quiet
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      drain_results();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic walk_plan(input stim_row_type rows[$]);
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_REG)
            write_reg(rows[i].reg_index, rows[i].reg_value);
         else
            send_poll(rows[i].poll, rows[i].typed, rows[i].want);
      end
   endtask

   task automatic run_random(input int count, input bit wide, input bit idle_on);
      logic [3:0] a;
      for (int n = 0; n < count; n++) begin
         if (idle_on && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 13));
         else if (idle_on && $urandom_range(0, 63) == 0)
            drain_results();
         do
            a = 4'($urandom_range(0, ADAPTORS - 1));
         while (!wide && a == FRESH_ADAPTOR);
         send_poll(next_poll(a, wide), 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      reset      <= 1'b1;
      start      <= 1'b0;
      req_data   <= '0;
      poll_typed <= 1'b0;
      poll_want  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_MAX_NARROW;
      csr_wdata  <= '0;
      for (int i = 0; i < ADAPTORS; i++) begin
         for (int k = 0; k < 2; k++)
            gen_bytes[i][k] = {32'd0, $urandom};
         for (int k = 0; k < 6; k++)
            gen_events[i][k] = $urandom;
      end

      // Narrow byte mode: first samples, wraps, limit boundaries, unused registers
      narrow_plan.push_back(reg_row(CSR_MAX_NARROW, 64'hDEAD_BEEF_FFFF_FFFF));
      narrow_plan.push_back(checked_row(poll_of(4'd0, 0, 0, 0, 0, 0, 0, 0, 0),
                                        totals_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0)));
      narrow_plan.push_back(checked_row(
         poll_of(4'd15, LOW_WORD, '1, '1, '1, LOW_WORD, '1, '1, '1),
         totals_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0)));
      narrow_plan.push_back(checked_row(poll_of(4'd0, 16, 1, 2, 3, 32, 4, 5, 6),
                                        totals_of(16, 1, 2, 3, 32, 4, 5, 6, 0, 0, 0)));
      narrow_plan.push_back(checked_row(poll_of(4'd15, 0, 0, 0, 0, 0, 0, 0, 0),
                                        totals_of(1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0)));
      narrow_plan.push_back(poll_row(poll_of(4'd0, 5, 1, 2, 3, 32, 4, 5, 6)));
      narrow_plan.push_back(reg_row(CSR_MAX_NARROW, 64'd100));
      narrow_plan.push_back(poll_row(poll_of(4'd0, 105, 101, 2, 3, 132, 104, 5, 6)));
      narrow_plan.push_back(poll_row(poll_of(4'd0, 105, 202, 2, 3, 132, 104, 5, 6)));
      narrow_plan.push_back(poll_row(poll_of(4'd0, 105, 202, 2, 3, 233, 104, 5, 6)));
      narrow_plan.push_back(poll_row(poll_of(4'd0, 105, 202, 2, 3, 233, 205, 5, 6)));
      narrow_plan.push_back(poll_row(poll_of(4'd0, 206, 202, 2, 3, 233, 205, 5, 6)));
      narrow_plan.push_back(poll_row(poll_of(4'd0, 206, 202, 32'hFFFF_FFF2, 3, 233, 205,
                                             5, 0)));
      narrow_plan.push_back(reg_row(CSR_MAX_NARROW, 64'd0));
      narrow_plan.push_back(reg_row(CSR_UNUSED_A, '1));
      narrow_plan.push_back(poll_row(poll_of(4'd0, 206, 202, 32'hFFFF_FFF2, 3, 233, 205,
                                             5, 0)));
      narrow_plan.push_back(poll_row(poll_of(4'd0, 206, 202, 32'hFFFF_FFF2, 3, 233, 205,
                                             6, 0)));
      narrow_plan.push_back(poll_row(poll_of(4'd0, 207, 202, 32'hFFFF_FFF2, 3, 233, 205,
                                             6, 0)));
      narrow_plan.push_back(reg_row(CSR_MAX_NARROW, LOW_WORD));
      narrow_plan.push_back(checked_row(
         poll_of(4'd7, 32'h8000_0000, '1, 32'h5555_5555, 32'hAAAA_AAAA, 1, 0, 7, 9),
         totals_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0)));

      // Switch to wide byte counters on a seen adaptor, then wide limits
      wide_plan.push_back(reg_row(CSR_MAX_NARROW, 64'd1000));
      wide_plan.push_back(reg_row(CSR_MAX_WIDE, 64'd0));
      wide_plan.push_back(poll_row(poll_of(4'd5, 64'h1000, 10, 0, 0, 64'h2000, 20, 0, 0)));
      wide_plan.push_back(poll_row(poll_of(4'd5, 64'h1_0000_1010, 11, 0, 0, 64'h2010, 20,
                                           0, 0)));
      wide_plan.push_back(poll_row(poll_of(4'd5, 64'h1_0000_1010, 11, 0, 0, 64'h2010, 20,
                                           0, 0)));
      wide_plan.push_back(poll_row(poll_of(4'd5, 64'h1_0000_1011, 11, 0, 0, 64'h2010, 20,
                                           0, 0)));
      wide_plan.push_back(checked_row(poll_of(FRESH_ADAPTOR, 0, '1, '1, '1, '1, '1, '1, '1),
                                      totals_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1)));
      wide_plan.push_back(reg_row(CSR_MAX_WIDE, 64'h1_0000_0000));
      wide_plan.push_back(poll_row(poll_of(4'd5, 64'h2_0000_1011, 11, 0, 0, 64'h2010, 20,
                                           0, 0)));
      wide_plan.push_back(poll_row(poll_of(4'd5, 64'h2_0000_1011, 11, 0, 0,
                                           64'h1_0000_2011, 20, 0, 0)));
      wide_plan.push_back(poll_row(poll_of(4'd5, 64'h2_0000_1011, 1012, 0, 0,
                                           64'h1_0000_2011, 20, 0, 0)));
      wide_plan.push_back(reg_row(CSR_MAX_WIDE, '1));
      wide_plan.push_back(poll_row(poll_of(4'd5, '1, 1012, 0, 0, 64'h1_0000_2011, 20, 0, 0)));
      wide_plan.push_back(poll_row(poll_of(4'd5, 0, 1012, 0, 0, 64'h1_0000_2011, 20, 0, 0)));
      wide_plan.push_back(reg_row(CSR_UNUSED_B, 64'd0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      walk_plan(narrow_plan);

      // Random polls in 32-bit byte mode over several limit settings
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_MAX_NARROW, LOW_WORD);
               write_reg(CSR_MAX_WIDE, 64'd0);
            end
            1: write_reg(CSR_MAX_NARROW, 64'd4000);
            2: write_reg(CSR_MAX_NARROW, {$urandom, 32'($urandom_range(2000, 9000))});
            default: write_reg(CSR_MAX_NARROW, {$urandom, $urandom});
         endcase
         run_random(90, 1'b0, phase != 1);
      end

      walk_plan(wide_plan);

      // Random polls with 64-bit byte counters; the last phase runs without gaps
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_MAX_NARROW, 64'd5000);
               write_reg(CSR_MAX_WIDE, '1);
            end
            1: write_reg(CSR_MAX_WIDE, 64'h8000);
            2: write_reg(CSR_MAX_WIDE, 64'($urandom_range(3000, 9000)));
            default: begin
               write_reg(CSR_MAX_NARROW, 64'($urandom_range(2000, 9000)));
               write_reg(CSR_MAX_WIDE, {$urandom, $urandom});
            end
         endcase
         run_random(90, 1'b1, phase != 3);
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[files.f]
rtl/icda_pkg.sv
rtl/icda_delta.sv
rtl/icda_accum.sv
rtl/interface_counter_delta_accumulator.sv
sim/testbench.sv
